>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the duty generator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Check a property outside reset.
`define ASSERT_ACTIVE(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

>>> hdl/svpwm_pkg.sv
// ---------------------------------------------------------------------------
// SVPWM package
// Widths, constants, word types and the sine table for the duty generator.
// ---------------------------------------------------------------------------
package svpwm_pkg;

   localparam int ANGLE_BITS       = 16;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_BITS        = 16;

   localparam int K_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int ROM_ADDR = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int M_BITS   = 33;   // amplitude * sqrt3 quotient
   localparam int C_BITS   = 16;   // compare and config width
   localparam int SEC_BITS = 3;

   localparam logic [16:0] SQRT3_Q16 = 17'd113512;
   localparam longint unsigned PI_THIRD_Q30 = 64'd1124419809;

   typedef logic [SINE_BITS-1:0] sine_rom_type [SINE_TABLE_DEPTH+1];

   // front stage result entering the divider
   typedef struct packed {
      logic [M_BITS-1:0]   dividend;
      logic [SEC_BITS-1:0] sector;
      logic [K_BITS-1:0]   k;
   } front_type;

   // divider result entering the duty stages
   typedef struct packed {
      logic [M_BITS-1:0]   m;
      logic [SEC_BITS-1:0] sector;
      logic [K_BITS-1:0]   k;
   } ratio_type;

   // Build sin over one sector by a Taylor series in Q30.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned s;
      longint sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (longint'(k) * PI_THIRD_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         term = ((term * x2) >> 30) / 6;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 20;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 42;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 72;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 110;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 156;
         sum = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         s = longint'(sum);
         rom[k] = SINE_BITS'(((s << SINE_BITS) + (64'd1 << 29)) >> 30);
      end
      return rom;
   endfunction

endpackage

>>> hdl/svpwm_seven_segment_duty_top.sv
// ---------------------------------------------------------------------------
// Seven-segment SVPWM duty generator
// Sector, active times and clamped compare values for one angle per word.
// ---------------------------------------------------------------------------
// Pipeline from input word to result word: front, 33 divider stages,
//   then sine read, two multiply pairs, zero split and duty stage.
// Throughput: one word per cycle; the whole pipeline holds when the result
//   is stalled. Synchronous reset clears all valid bits and restores
//   bus_voltage to 28378 and pwm_period to 8400.
module svpwm_seven_segment_duty_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // amplitude[15:0], phase[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // compare_first, compare_second,
                                    // compare_third, sector[50:48],
                                    // overmodulated[51], zero fill
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [0:0] REG_BUS_VOLTAGE = 1'd0;
   localparam logic [0:0] REG_PWM_PERIOD  = 1'd1;

   logic [15:0]           bus_ff, period_ff;
   logic                  advance;
   logic                  front_valid, div_valid, out_valid;
   svpwm_pkg::front_type  front_word;
   svpwm_pkg::ratio_type  div_word;
   logic [15:0]           cmp_a, cmp_b, cmp_c;
   logic [2:0]            sector;
   logic                  over;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff    <= 16'd28378;
         period_ff <= 16'd8400;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_BUS_VOLTAGE: bus_ff    <= csr_wdata;
            REG_PWM_PERIOD:  period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // move the whole pipeline unless the result word is stalled
   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;

   svpwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .amplitude (req_tdata[15:0]),
      .phase     (req_tdata[31:16]),
      .out_valid (front_valid),
      .out_word  (front_word)
   );

   svpwm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (bus_ff),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_word  (div_word)
   );

   svpwm_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .period    (period_ff),
      .in_valid  (div_valid),
      .in_word   (div_word),
      .out_valid (out_valid),
      .cmp_a     (cmp_a),
      .cmp_c     (cmp_c),
      .cmp_b     (cmp_b),
      .sector    (sector),
      .over      (over)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {4'd0, over, sector, cmp_b, cmp_c, cmp_a};

endmodule

>>> hdl/svpwm_front.sv
// ---------------------------------------------------------------------------
// SVPWM front stage
// Finds the sector and sine index and forms the scaled amplitude dividend.
// ---------------------------------------------------------------------------
module svpwm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [15:0]               amplitude,
   input  logic [15:0]               phase,
   output logic                      out_valid,
   output svpwm_pkg::front_type      out_word
);

   localparam int AB = svpwm_pkg::ANGLE_BITS;

   logic [AB-1:0]                       ang;
   logic [AB+2:0]                       s6;
   logic [AB-1:0]                       rem;
   logic [AB+svpwm_pkg::ROM_ADDR-1:0]   kprod;
   logic [svpwm_pkg::ROM_ADDR-1:0]      kfull;
   svpwm_pkg::front_type                word_in;
   svpwm_pkg::front_type                word_ff;
   logic                                vld_ff;

   // split the angle into sector and local index
   always_comb begin
      ang   = phase[AB-1:0];
      s6    = (AB+3)'(ang) * (AB+3)'(6);
      rem   = s6[AB-1:0];
      kprod = (AB+svpwm_pkg::ROM_ADDR)'(rem)
            * (AB+svpwm_pkg::ROM_ADDR)'(svpwm_pkg::SINE_TABLE_DEPTH);
      kfull = kprod[AB+svpwm_pkg::ROM_ADDR-1:AB];
      word_in.sector   = s6[AB+2:AB];
      word_in.dividend = svpwm_pkg::M_BITS'(amplitude) * svpwm_pkg::M_BITS'(svpwm_pkg::SQRT3_Q16);
      if (kfull >= svpwm_pkg::ROM_ADDR'(svpwm_pkg::SINE_TABLE_DEPTH)) begin
         word_in.k = svpwm_pkg::K_BITS'(svpwm_pkg::SINE_TABLE_DEPTH - 1);
      end else begin
         word_in.k = kfull[svpwm_pkg::K_BITS-1:0];
      end
   end

   // hold the word until the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_word  = word_ff;

endmodule

>>> hdl/svpwm_divider.sv
// ---------------------------------------------------------------------------
// SVPWM divider
// Restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module svpwm_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [15:0]               divisor,
   input  logic                      in_valid,
   input  svpwm_pkg::front_type      in_word,
   output logic                      out_valid,
   output svpwm_pkg::ratio_type      out_word
);

   localparam int MW = svpwm_pkg::M_BITS;

   typedef struct packed {
      logic [MW-1:0]                 n;
      logic [15:0]                   rem;
      logic [MW-1:0]                 q;
      logic [svpwm_pkg::SEC_BITS-1:0] sector;
      logic [svpwm_pkg::K_BITS-1:0]  k;
   } div_stage_type;

   logic [15:0]   dvs;
   div_stage_type load_word;
   div_stage_type stage_ff [MW];
   logic          vld_ff   [MW];

   // zero bus voltage divides as one
   assign dvs = (divisor == 16'd0) ? 16'd1 : divisor;

   // load the first stage
   always_comb begin
      load_word.n      = in_word.dividend;
      load_word.rem    = 16'd0;
      load_word.q      = '0;
      load_word.sector = in_word.sector;
      load_word.k      = in_word.k;
   end

   for (genvar i = 0; i < MW; i++) begin : g_step
      div_stage_type cur;
      logic          cur_vld;
      logic [16:0]   trial;
      logic          qbit;
      div_stage_type nxt_in;

      // pick the word entering this stage
      if (i == 0) begin : g_head
         assign cur     = load_word;
         assign cur_vld = in_valid;
      end else begin : g_link
         assign cur     = stage_ff[i-1];
         assign cur_vld = vld_ff[i-1];
      end

      // shift in one dividend bit and try the subtract
      always_comb begin
         trial  = {cur.rem, cur.n[MW-1]};
         qbit   = (trial >= {1'b0, dvs});
         nxt_in = cur;
         nxt_in.n = {cur.n[MW-2:0], 1'b0};
         nxt_in.q = {cur.q[MW-2:0], qbit};
         if (qbit) begin
            nxt_in.rem = 16'(trial - {1'b0, dvs});
         end else begin
            nxt_in.rem = trial[15:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[i] <= nxt_in;
         end
      end
   end

   assign out_valid       = vld_ff[MW-1];
   assign out_word.m      = stage_ff[MW-1].q;
   assign out_word.sector = stage_ff[MW-1].sector;
   assign out_word.k      = stage_ff[MW-1].k;

endmodule

>>> hdl/svpwm_duty.sv
// ---------------------------------------------------------------------------
// SVPWM duty stages
// Sine lookup, active times, zero split and per-sector compare values.
// ---------------------------------------------------------------------------
module svpwm_duty (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [15:0]               period,
   input  logic                      in_valid,
   input  svpwm_pkg::ratio_type      in_word,
   output logic                      out_valid,
   output logic [15:0]               cmp_a,
   output logic [15:0]               cmp_c,
   output logic [15:0]               cmp_b,
   output logic [2:0]                sector,
   output logic                      over
);

   localparam int MW = svpwm_pkg::M_BITS;
   localparam int SB = svpwm_pkg::SINE_BITS;
   localparam int NS = 7;
   localparam svpwm_pkg::sine_rom_type SINE_ROM = svpwm_pkg::build_sine_rom();

   logic [svpwm_pkg::SEC_BITS-1:0] sec_ff [NS];
   logic                           vld_ff [NS];

   logic [SB-1:0]        rom_a_ff, rom_b_ff;
   logic [MW-1:0]        m_ff;
   logic [MW-16+SB-1:0]  pa_hi_ff, pb_hi_ff;
   logic [16+SB-1:0]     pa_lo_ff, pb_lo_ff;
   logic [MW-1:0]        ta_ff, tb_ff;
   logic [MW+SB:0]       pa_sum, pb_sum;
   logic [MW-16+15:0]    ca_hi_ff, cb_hi_ff;
   logic [31:0]          ca_lo_ff, cb_lo_ff;
   logic [MW+16:0]       ca_sum, cb_sum;
   logic [MW-1:0]        ca_ff, cb_ff;
   logic signed [MW+2:0] z0;
   logic signed [MW+2:0] h_ff;
   logic [MW-1:0]        ca2_ff, cb2_ff;
   logic                 over_ff, over_out_ff;
   logic signed [MW+3:0] da, db, dc, hh, sa, sb_s;
   logic [15:0]          a_ff, b_ff, c_ff;
   logic [svpwm_pkg::ROM_ADDR-1:0] addr_a;

   assign addr_a = svpwm_pkg::ROM_ADDR'(svpwm_pkg::SINE_TABLE_DEPTH)
                 - svpwm_pkg::ROM_ADDR'(in_word.k);

   // advance valid and sector along the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sec_ff[0] <= in_word.sector;
         for (int i = 1; i < NS; i++) begin
            sec_ff[i] <= sec_ff[i-1];
         end
      end
   end

   // read both sines from the table
   always_ff @(posedge clock) begin
      if (advance) begin
         rom_a_ff <= SINE_ROM[addr_a];
         rom_b_ff <= SINE_ROM[svpwm_pkg::ROM_ADDR'(in_word.k)];
         m_ff     <= in_word.m;
      end
   end

   // partial products of ratio times sine
   always_ff @(posedge clock) begin
      if (advance) begin
         pa_hi_ff <= (MW-16+SB)'(m_ff[MW-1:16]) * (MW-16+SB)'(rom_a_ff);
         pb_hi_ff <= (MW-16+SB)'(m_ff[MW-1:16]) * (MW-16+SB)'(rom_b_ff);
         pa_lo_ff <= (16+SB)'(m_ff[15:0]) * (16+SB)'(rom_a_ff);
         pb_lo_ff <= (16+SB)'(m_ff[15:0]) * (16+SB)'(rom_b_ff);
      end
   end

   // round the active-time fractions
   always_comb begin
      pa_sum = ((MW+SB+1)'(pa_hi_ff) << 16) + (MW+SB+1)'(pa_lo_ff)
             + ((MW+SB+1)'(1) << (SB-1));
      pb_sum = ((MW+SB+1)'(pb_hi_ff) << 16) + (MW+SB+1)'(pb_lo_ff)
             + ((MW+SB+1)'(1) << (SB-1));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ta_ff <= pa_sum[SB+MW-1:SB];
         tb_ff <= pb_sum[SB+MW-1:SB];
      end
   end

   // partial products of fractions times period
   always_ff @(posedge clock) begin
      if (advance) begin
         ca_hi_ff <= (MW)'(ta_ff[MW-1:16]) * (MW)'(period);
         cb_hi_ff <= (MW)'(tb_ff[MW-1:16]) * (MW)'(period);
         ca_lo_ff <= 32'(ta_ff[15:0]) * 32'(period);
         cb_lo_ff <= 32'(tb_ff[15:0]) * 32'(period);
      end
   end

   // round the active times to counts
   always_comb begin
      ca_sum = ((MW+17)'(ca_hi_ff) << 16) + (MW+17)'(ca_lo_ff) + (MW+17)'(32768);
      cb_sum = ((MW+17)'(cb_hi_ff) << 16) + (MW+17)'(cb_lo_ff) + (MW+17)'(32768);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ca_ff <= ca_sum[MW+15:16];
         cb_ff <= cb_sum[MW+15:16];
      end
   end

   // split the zero time, floor toward minus infinity
   assign z0 = $signed((MW+3)'(period)) - $signed((MW+3)'(ca_ff))
             - $signed((MW+3)'(cb_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         h_ff    <= z0 >>> 1;
         over_ff <= z0[MW+2];
         ca2_ff  <= ca_ff;
         cb2_ff  <= cb_ff;
      end
   end

   // form the sector duties
   always_comb begin
      hh   = (MW+4)'(h_ff);
      sa   = hh + $signed((MW+4)'(ca2_ff));
      sb_s = hh + $signed((MW+4)'(cb2_ff));
      unique case (sec_ff[5])
         3'd0: begin da = sa + $signed((MW+4)'(cb2_ff)); db = sb_s; dc = hh; end
         3'd1: begin da = sa; db = sa + $signed((MW+4)'(cb2_ff)); dc = hh; end
         3'd2: begin da = hh; db = sa + $signed((MW+4)'(cb2_ff)); dc = sb_s; end
         3'd3: begin da = hh; db = sa; dc = sa + $signed((MW+4)'(cb2_ff)); end
         3'd4: begin da = sb_s; db = hh; dc = sa + $signed((MW+4)'(cb2_ff)); end
         default: begin da = sa + $signed((MW+4)'(cb2_ff)); db = hh; dc = sa; end
      endcase
   end

   function automatic logic [15:0] clamp(input logic signed [MW+3:0] v,
                                         input logic [15:0] top);
      logic [15:0] r;
      if (v < 0) begin
         r = 16'd0;
      end else if (v > $signed((MW+4)'(top))) begin
         r = top;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // clamp into the output register
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff        <= clamp(da, period);
         b_ff        <= clamp(db, period);
         c_ff        <= clamp(dc, period);
         over_out_ff <= over_ff;
      end
   end

   assign out_valid = vld_ff[6];
   assign cmp_a     = a_ff;
   assign cmp_b     = b_ff;
   assign cmp_c     = c_ff;
   assign sector    = sec_ff[6];
   assign over      = over_out_ff;

endmodule

>>> hdl/svpwm_checker.sv
// ---------------------------------------------------------------------------
// SVPWM port checker
// Watches the top-level ports for handshake and result sanity.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svpwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)
   `ASSERT_ACTIVE(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_ACTIVE(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready)
   `ASSERT_ACTIVE(a_sector_range, clock, reset, rsp_tvalid |-> rsp_tdata[50:48] <= 3'd5)

endmodule

bind svpwm_seven_segment_duty_top svpwm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
